// ===== src/fcpu_pkg.sv =====
// Package: shared types, constants and tables of the fly camera pose update block.
`default_nettype none
package fcpu_pkg;

  localparam int unsigned CordicStepsDef = 14;
  localparam int unsigned AtanCount      = 24;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [CfgIdxW-1:0] CFG_MOVE_SPEED  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOK_SENS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLAMP_PITCH = 2'd2;

  localparam logic [15:0] MoveSpeedRst = 16'd640;
  localparam logic [15:0] LookSensRst  = 16'd6554;

  localparam logic signed [16:0] PitchLimit = 17'sd16202;
  localparam logic signed [34:0] CordicGain = 35'sd652032874;
  localparam logic signed [15:0] OneQ14     = 16'sd16384;

  // move directions
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE_MUL,
    ST_MOVE_ADD,
    ST_LOOK_MUL,
    ST_LOOK_DIV,
    ST_LOOK_ANG,
    ST_CORDIC_INIT,
    ST_CORDIC_RUN,
    ST_CORDIC_DONE,
    ST_FRONT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic move_mul;
    logic move_add;
    logic look_mul;
    logic look_div;
    logic look_ang;
    logic cordic_init;
    logic cordic_step;
    logic cordic_done;
    logic front;
  } cmd_t;

  typedef struct packed {
    logic is_look;
    logic cordic_last;
    logic second_angle;
  } status_t;

  function automatic logic signed [34:0] atan_val(input logic [4:0] i);
    logic signed [34:0] r;
    begin
      case (i)
        5'd0: r = 35'sd2097152;   5'd1: r = 35'sd1238021;
        5'd2: r = 35'sd654136;    5'd3: r = 35'sd332050;
        5'd4: r = 35'sd166669;    5'd5: r = 35'sd83416;
        5'd6: r = 35'sd41718;     5'd7: r = 35'sd20860;
        5'd8: r = 35'sd10430;     5'd9: r = 35'sd5215;
        5'd10: r = 35'sd2608;     5'd11: r = 35'sd1304;
        5'd12: r = 35'sd652;      5'd13: r = 35'sd326;
        5'd14: r = 35'sd163;      5'd15: r = 35'sd81;
        5'd16: r = 35'sd41;       5'd17: r = 35'sd20;
        5'd18: r = 35'sd10;       5'd19: r = 35'sd5;
        5'd20: r = 35'sd3;        5'd21: r = 35'sd1;
        5'd22: r = 35'sd1;        default: r = 35'sd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/fcpu_ctrl.sv =====
// Controller: sequences move, look and CORDIC steps.
`default_nettype none
module fcpu_ctrl
  import fcpu_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.is_look ? ST_LOOK_MUL : ST_MOVE_MUL;
      end
      ST_MOVE_MUL:    state_d = ST_MOVE_ADD;
      ST_MOVE_ADD:    state_d = ST_OUT;
      ST_LOOK_MUL:    state_d = ST_LOOK_DIV;
      ST_LOOK_DIV:    state_d = ST_LOOK_ANG;
      ST_LOOK_ANG:    state_d = ST_CORDIC_INIT;
      ST_CORDIC_INIT: state_d = ST_CORDIC_RUN;
      ST_CORDIC_RUN: begin
        if (status_i.cordic_last) state_d = ST_CORDIC_DONE;
      end
      ST_CORDIC_DONE: state_d = status_i.second_angle ? ST_FRONT : ST_CORDIC_INIT;
      ST_FRONT:       state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_MOVE_MUL:    cmd_o.move_mul    = 1'b1;
      ST_MOVE_ADD:    cmd_o.move_add    = 1'b1;
      ST_LOOK_MUL:    cmd_o.look_mul    = 1'b1;
      ST_LOOK_DIV:    cmd_o.look_div    = 1'b1;
      ST_LOOK_ANG:    cmd_o.look_ang    = 1'b1;
      ST_CORDIC_INIT: cmd_o.cordic_init = 1'b1;
      ST_CORDIC_RUN:  cmd_o.cordic_step = 1'b1;
      ST_CORDIC_DONE: cmd_o.cordic_done = 1'b1;
      ST_FRONT:       cmd_o.front       = 1'b1;
      ST_OUT:         out_valid_o       = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/fcpu_dp.sv =====
// Datapath: pose registers, move arithmetic, reciprocal divide and shared CORDIC.
`default_nettype none
module fcpu_dp
  import fcpu_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic               action_i,
  input  wire logic [2:0]         move_dir_i,
  input  wire logic [15:0]        delta_time_i,
  input  wire logic signed [15:0] x_offset_i,
  input  wire logic signed [15:0] y_offset_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [15:0]      front_x_o,
  output logic signed [15:0]      front_y_o,
  output logic signed [15:0]      front_z_o,
  output logic signed [15:0]      side_x_o,
  output logic signed [15:0]      side_z_o,
  output logic [15:0]             yaw_angle_o,
  output logic signed [15:0]      pitch_angle_o
);

  localparam int unsigned Steps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
  localparam int unsigned ItW   = $clog2(AtanCount + 1);
  localparam logic [ItW-1:0] LastIt = ItW'(Steps - 1);
  localparam logic [15:0] DegDiv = 16'd5760;
  // ceil(2^30 / 45): exact quotient for any dividend below 2^24
  localparam logic [24:0] DegRecip = 25'd23860930;

  // configuration
  logic [15:0] speed_q, sens_q;
  logic        clamp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= MoveSpeedRst;
      sens_q  <= LookSensRst;
      clamp_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOVE_SPEED:  speed_q <= cfg_data_i;
        CFG_LOOK_SENS:   sens_q  <= cfg_data_i;
        CFG_CLAMP_PITCH: clamp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item capture
  logic [2:0]        dir_q;
  logic [15:0]       dt_q;
  logic signed [15:0] xo_q, yo_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      dir_q <= move_dir_i;
      dt_q  <= delta_time_i;
      xo_q  <= x_offset_i;
      yo_q  <= y_offset_i;
    end
  end

  // pose state
  logic signed [31:0] pos_q [3];
  logic signed [15:0] front_q [3];
  logic signed [15:0] sx_q, sz_q;
  logic [15:0]        yaw_q;
  logic signed [15:0] pitch_q;

  // move: step, then per-axis product and saturating add
  logic [23:0] step_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.move_mul) step_q <= 24'(({16'd0, speed_q} * {16'd0, dt_q}) >> 8);
  end

  logic signed [15:0] vsel [3];
  logic               neg;
  logic               dir_ok;
  always_comb begin
    vsel[0] = 16'sd0; vsel[1] = 16'sd0; vsel[2] = 16'sd0;
    neg = 1'b0; dir_ok = 1'b1;
    unique case (dir_q)
      DIR_FWD:   begin vsel = front_q; end
      DIR_BACK:  begin vsel = front_q; neg = 1'b1; end
      DIR_LEFT:  begin vsel[0] = sx_q; vsel[2] = sz_q; neg = 1'b1; end
      DIR_RIGHT: begin vsel[0] = sx_q; vsel[2] = sz_q; end
      DIR_UP:    begin vsel[1] = OneQ14; end
      DIR_DOWN:  begin vsel[1] = OneQ14; neg = 1'b1; end
      default:   dir_ok = 1'b0;
    endcase
  end

  logic signed [40:0] prod [3];
  logic signed [26:0] dlt  [3];
  logic signed [33:0] sum  [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = 41'(vsel[k]) * $signed({17'd0, step_q});
      dlt[k]  = 27'(prod[k] >>> 14);
      sum[k]  = neg ? 34'(pos_q[k]) - 34'(dlt[k]) : 34'(pos_q[k]) + 34'(dlt[k]);
    end
  end

  // look: rounded magnitudes, then divide by 5760 as a shift by 7 and a
  // multiply by the reciprocal of 45
  logic [23:0] num_q [2];
  logic        nsg_q [2];
  logic [18:0] quo_q [2];
  logic signed [32:0] lp [2];
  always_comb begin
    lp[0] = 33'(xo_q) * $signed({17'd0, sens_q});
    lp[1] = 33'(yo_q) * $signed({17'd0, sens_q});
  end

  logic [48:0] qp [2];
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qp[j] = {25'd0, num_q[j]} * {24'd0, DegRecip};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_mul) begin
      for (int j = 0; j < 2; j++) begin
        nsg_q[j] <= lp[j][32];
        num_q[j] <= 24'(((lp[j][32] ? -lp[j] : lp[j]) + 33'(DegDiv >> 1)) >>> 7);
      end
    end else if (cmd_i.look_div) begin
      for (int j = 0; j < 2; j++) begin
        quo_q[j] <= qp[j][48:30];
      end
    end
  end

  logic signed [33:0] dyaw, dpit, pnew;
  always_comb begin
    dyaw = nsg_q[0] ? -$signed({15'd0, quo_q[0]}) : $signed({15'd0, quo_q[0]});
    dpit = nsg_q[1] ? -$signed({15'd0, quo_q[1]}) : $signed({15'd0, quo_q[1]});
    pnew = 34'(pitch_q) + dpit;
    if (clamp_q) begin
      if (pnew > 34'(PitchLimit)) pnew = 34'(PitchLimit);
      if (pnew < -34'(PitchLimit)) pnew = -34'(PitchLimit);
    end
  end

  // CORDIC, run once for yaw and once for pitch
  logic signed [34:0] cx_q, cy_q, cz_q;
  logic [ItW-1:0]     it_q;
  logic [1:0]         quad_q;
  logic               second_q;
  logic signed [15:0] cyaw_q, syaw_q, cpit_q, spit_q;
  logic [15:0]        ang, ared;

  always_comb begin
    ang  = second_q ? pitch_q : yaw_q;
    ared = ang + 16'd8192;
  end

  function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
    logic signed [34:0] r;
    begin
      r = (v + 35'sd32768) >>> 16;
      if (r > 35'sd16384) r = 35'sd16384;
      if (r < -35'sd16384) r = -35'sd16384;
      return 16'(r);
    end
  endfunction

  logic signed [15:0] cr, sr, cq, sq;
  always_comb begin
    cr = to_q14(cx_q);
    sr = to_q14(cy_q);
    case (quad_q)
      2'd0:    begin cq = cr;  sq = sr;  end
      2'd1:    begin cq = -sr; sq = cr;  end
      2'd2:    begin cq = -cr; sq = -sr; end
      default: begin cq = sr;  sq = -cr; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_ang) begin
      second_q <= 1'b0;
    end else if (cmd_i.cordic_init) begin
      quad_q <= ared[15:14];
      cx_q   <= CordicGain;
      cy_q   <= '0;
      cz_q   <= (35'($signed({1'b0, ared[13:0]})) - 35'sd8192) <<< 8;
      it_q   <= '0;
    end else if (cmd_i.cordic_step) begin
      it_q <= it_q + ItW'(1);
      if (!cz_q[34]) begin
        cx_q <= cx_q - (cy_q >>> it_q);
        cy_q <= cy_q + (cx_q >>> it_q);
        cz_q <= cz_q - atan_val(5'(it_q));
      end else begin
        cx_q <= cx_q + (cy_q >>> it_q);
        cy_q <= cy_q - (cx_q >>> it_q);
        cz_q <= cz_q + atan_val(5'(it_q));
      end
    end else if (cmd_i.cordic_done) begin
      second_q <= 1'b1;
      if (second_q) begin
        cpit_q <= cq; spit_q <= sq;
      end else begin
        cyaw_q <= cq; syaw_q <= sq;
      end
    end
  end

  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    begin
      p = (32'(a) * 32'(b) + 32'sd8192) >>> 14;
      return 16'(p);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) pos_q[k] <= '0;
      front_q[0] <= '0; front_q[1] <= '0; front_q[2] <= -OneQ14;
      sx_q <= OneQ14; sz_q <= '0;
      yaw_q <= 16'd49152; pitch_q <= '0;
    end else begin
      if (cmd_i.move_add && dir_ok) begin
        for (int k = 0; k < 3; k++) begin
          if (sum[k] > 34'sh07FFFFFFF) pos_q[k] <= 32'sh7FFFFFFF;
          else if (sum[k] < -34'sh080000000) pos_q[k] <= 32'sh80000000;
          else pos_q[k] <= 32'(sum[k]);
        end
      end
      if (cmd_i.look_ang) begin
        yaw_q   <= yaw_q + 16'(dyaw);
        pitch_q <= 16'(pnew);
      end
      if (cmd_i.front) begin
        front_q[0] <= mul_q14(cyaw_q, cpit_q);
        front_q[1] <= spit_q;
        front_q[2] <= mul_q14(syaw_q, cpit_q);
        sx_q <= -syaw_q;
        sz_q <= cyaw_q;
      end
    end
  end

  always_comb begin
    status_o.is_look      = action_i;
    status_o.cordic_last  = (it_q == LastIt);
    status_o.second_angle = second_q;
  end

  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign front_x_o = front_q[0];
  assign front_y_o = front_q[1];
  assign front_z_o = front_q[2];
  assign side_x_o = sx_q;
  assign side_z_o = sz_q;
  assign yaw_angle_o = yaw_q;
  assign pitch_angle_o = pitch_q;

endmodule
`default_nettype wire

// ===== src/fly_camera_pose_update.sv =====
// Top level of the fly camera pose update block.
// Move beat: after accept, the step multiply and then the saturating add run before the result leaves.
// Look beat: the scaling multiply, the reciprocal divide and two CORDIC passes on one
// unit; steps are capped at 24.
// One beat at a time: the next can be taken in the cycle after the result leaves.
// Reset (asynchronous, active low) restores default settings and the initial pose.
`default_nettype none
module fly_camera_pose_update
  import fcpu_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                action_i,
  input  wire logic [2:0]          move_dir_i,
  input  wire logic [15:0]         delta_time_i,
  input  wire logic signed [15:0]  x_offset_i,
  input  wire logic signed [15:0]  y_offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic signed [31:0]       pos_z_o,
  output logic signed [15:0]       front_x_o,
  output logic signed [15:0]       front_y_o,
  output logic signed [15:0]       front_z_o,
  output logic signed [15:0]       side_x_o,
  output logic signed [15:0]       side_z_o,
  output logic [15:0]              yaw_angle_o,
  output logic signed [15:0]       pitch_angle_o
);

  cmd_t    cmd;
  status_t status;

  fcpu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  fcpu_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i, .move_dir_i, .delta_time_i, .x_offset_i, .y_offset_i,
    .cmd_i(cmd), .status_o(status),
    .pos_x_o, .pos_y_o, .pos_z_o, .front_x_o, .front_y_o, .front_z_o,
    .side_x_o, .side_z_o, .yaw_angle_o, .pitch_angle_o
  );

endmodule
`default_nettype wire

// ===== src/fcpu_checker.sv =====
// Port-level checker for the fly camera pose update block, with its bind.
`default_nettype none
module fcpu_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] side_x_o,
  input wire logic signed [15:0] side_z_o,
  input wire logic signed [15:0] pitch_angle_o
);

  // a beat accepted means the block is busy until its result goes
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pitch_angle_o)))
    else $error("stalled result changed");

  a_side_stable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !in_valid_i) |=> ($stable(side_x_o) && $stable(side_z_o)))
    else $error("side vector moved while idle");

endmodule

bind fly_camera_pose_update fcpu_checker u_fcpu_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .side_x_o, .side_z_o, .pitch_angle_o
);
`default_nettype wire
